FILE: sv/lscr_pkg.sv
`timescale 1ns / 1ps

package lscr_pkg;

    // request codes
    localparam logic [2:0] REQ_STAGE    = 3'd0;
    localparam logic [2:0] REQ_APPLY    = 3'd1;
    localparam logic [2:0] REQ_FRAME    = 3'd2;
    localparam logic [2:0] REQ_CHECK    = 3'd3;
    localparam logic [2:0] REQ_ROLLBACK = 3'd4;

    // setting addresses
    localparam logic [15:0] ADDR_SLAVE  = 16'd0;
    localparam logic [15:0] ADDR_BAUD   = 16'd1;
    localparam logic [15:0] ADDR_PARITY = 16'd2;
    localparam logic [15:0] ADDR_STOP   = 16'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLAVE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLAVE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAUD_SIZE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RB_WINDOW   = 8'd3;

    localparam logic [7:0]  RST_MIN_SLAVE = 8'd1;
    localparam logic [7:0]  RST_MAX_SLAVE = 8'd247;
    localparam logic [4:0]  RST_BAUD_SIZE = 5'd8;
    localparam logic [31:0] RST_RB_WINDOW = 32'd60000;

    localparam logic [1:0] PARITY_MAX = 2'd2;
    localparam logic [1:0] STOP_ONE   = 2'd1;
    localparam logic [1:0] STOP_TWO   = 2'd2;

    typedef struct packed {
        logic [7:0] slave;
        logic [3:0] baud;
        logic [1:0] parity;
        logic [1:0] stop;
    } word_t;

    localparam word_t RESET_WORD = '{slave: 8'd1, baud: 4'd0, parity: 2'd0, stop: 2'd1};

    typedef struct packed {
        logic [7:0]  min_slave_id;
        logic [7:0]  max_slave_id;
        logic [4:0]  baud_table_size;
        logic [31:0] rollback_window;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] reg_address;
        logic [15:0] write_value;
        logic        from_display;
        logic [31:0] now_ms;
        logic [7:0]  served_slave_id;
    } item_t;

    typedef struct packed {
        word_t       live;
        word_t       staged;
        word_t       prev;
        logic [15:0] revision;
        logic        armed;
        logic [31:0] applied_time;
    } state_t;

    typedef struct packed {
        logic        accepted;
        logic        rollback_due;
        word_t       live;
        word_t       staged;
        logic [15:0] revision;
        logic        pending;
    } result_t;

endpackage

FILE: sv/lscr_cfg.sv
`timescale 1ns / 1ps

module lscr_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [lscr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    output logic                               cfg_ready,
    output lscr_pkg::cfg_t                     cfg
);
    import lscr_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_slave_id    <= RST_MIN_SLAVE;
            cfg_reg.max_slave_id    <= RST_MAX_SLAVE;
            cfg_reg.baud_table_size <= RST_BAUD_SIZE;
            cfg_reg.rollback_window <= RST_RB_WINDOW;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_SLAVE: cfg_reg.min_slave_id    <= cfg_data[7:0];
                CFG_MAX_SLAVE: cfg_reg.max_slave_id    <= cfg_data[7:0];
                CFG_BAUD_SIZE: cfg_reg.baud_table_size <= cfg_data[4:0];
                CFG_RB_WINDOW: cfg_reg.rollback_window <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/lscr_step.sv
`timescale 1ns / 1ps

module lscr_step (
    input  lscr_pkg::cfg_t    cfg,
    input  lscr_pkg::state_t  st,
    input  lscr_pkg::item_t   item,
    output lscr_pkg::state_t  st_next,
    output lscr_pkg::result_t res
);
    import lscr_pkg::*;

    function automatic logic word_ok(input word_t w, input cfg_t c);
        word_ok = (w.slave >= c.min_slave_id) && (w.slave <= c.max_slave_id) &&
                  ({1'b0, w.baud} < c.baud_table_size) && (w.parity <= PARITY_MAX) &&
                  ((w.stop == STOP_ONE) || (w.stop == STOP_TWO));
    endfunction

    logic [31:0] elapsed;
    logic        due;
    word_t       cand;
    word_t       stage_word;
    logic        field_ok;
    logic        stage_ok;
    logic        rb_ok;
    logic        acc;
    state_t      nxt;

    assign elapsed = item.now_ms - st.applied_time;
    assign due     = st.armed && (elapsed >= cfg.rollback_window);
    assign rb_ok   = st.armed && (st.prev != st.live);

    // candidate starts from live for display writes, staged for bus writes
    always_comb begin
        cand       = item.from_display ? st.live : st.staged;
        stage_word = cand;
        field_ok   = 1'b0;
        if (item.reg_address == ADDR_SLAVE) begin
            field_ok = (item.write_value >= {8'd0, cfg.min_slave_id}) &&
                       (item.write_value <= {8'd0, cfg.max_slave_id});
            stage_word.slave = item.write_value[7:0];
        end else if (item.reg_address == ADDR_BAUD) begin
            field_ok = (item.write_value < {11'd0, cfg.baud_table_size}) &&
                       (item.write_value <= 16'd15);
            stage_word.baud = item.write_value[3:0];
        end else if (item.reg_address == ADDR_PARITY) begin
            field_ok = (item.write_value <= {14'd0, PARITY_MAX});
            stage_word.parity = item.write_value[1:0];
        end else if (item.reg_address == ADDR_STOP) begin
            field_ok = (item.write_value == {14'd0, STOP_ONE}) ||
                       (item.write_value == {14'd0, STOP_TWO});
            stage_word.stop = item.write_value[1:0];
        end
        stage_ok = field_ok && word_ok(stage_word, cfg);
    end

    always_comb begin
        nxt = st;
        acc = 1'b0;
        unique case (item.req_type)
            REQ_STAGE: begin
                if (stage_ok) begin
                    nxt.staged = stage_word;
                    acc        = 1'b1;
                end
            end
            REQ_APPLY: begin
                if (!word_ok(st.staged, cfg) || (st.staged == st.live)) begin
                    nxt.staged = st.live;
                end else begin
                    nxt.prev         = st.live;
                    nxt.live         = st.staged;
                    nxt.revision     = st.revision + 16'd1;
                    nxt.armed        = !item.from_display;
                    nxt.applied_time = item.now_ms;
                    acc              = 1'b1;
                end
            end
            REQ_FRAME: begin
                if (item.served_slave_id == st.live.slave) begin
                    nxt.armed = 1'b0;
                end
            end
            REQ_CHECK, REQ_ROLLBACK: begin
                // a check only acts once the window ran out
                if (item.req_type == REQ_ROLLBACK || due) begin
                    nxt.armed = 1'b0;
                    if (rb_ok) begin
                        nxt.live     = st.prev;
                        nxt.staged   = st.prev;
                        nxt.revision = st.revision + 16'd1;
                        acc          = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign st_next          = nxt;
    assign res.accepted     = acc;
    assign res.rollback_due = due;
    assign res.live         = nxt.live;
    assign res.staged       = nxt.staged;
    assign res.revision     = nxt.revision;
    assign res.pending      = nxt.armed;

endmodule

FILE: sv/link_settings_commit_rollback.sv
`timescale 1ns / 1ps

// Serial-link settings manager. Takes one request word per clock unless the
// result is stalled: requests are registered on entry, evaluated against the
// settings state in a single combinational pass, and the resulting word is
// held in an output register; the sustained rate is one word per cycle while
// m_ready stays high. A stalled result holds the state update of the
// following word until it is taken.
// Configuration writes are taken every cycle (cfg_ready is always high) and
// must only be issued while no request is in flight; indexes 0..3 select
// min slave ID, max slave ID, baud table size and rollback window, other
// indexes are ignored.
module link_settings_commit_rollback (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [15:0] s_reg_address,
    input  logic [15:0] s_write_value,
    input  logic        s_from_display,
    input  logic [31:0] s_now_ms,
    input  logic [7:0]  s_served_slave_id,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic        m_rollback_due,
    output logic [7:0]  m_live_slave,
    output logic [3:0]  m_live_baud,
    output logic [1:0]  m_live_parity,
    output logic [1:0]  m_live_stop,
    output logic [7:0]  m_staged_slave,
    output logic [3:0]  m_staged_baud,
    output logic [1:0]  m_staged_parity,
    output logic [1:0]  m_staged_stop,
    output logic [15:0] m_revision,
    output logic        m_confirm_pending
);
    import lscr_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    fire;

    lscr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    lscr_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.req_type        <= s_req_type;
            item_reg.reg_address     <= s_reg_address;
            item_reg.write_value     <= s_write_value;
            item_reg.from_display    <= s_from_display;
            item_reg.now_ms          <= s_now_ms;
            item_reg.served_slave_id <= s_served_slave_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.live         <= RESET_WORD;
            state_reg.staged       <= RESET_WORD;
            state_reg.prev         <= RESET_WORD;
            state_reg.revision     <= 16'd0;
            state_reg.armed        <= 1'b0;
            state_reg.applied_time <= 32'd0;
            out_valid_reg          <= 1'b0;
        end else if (fire) begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_accepted        = res_reg.accepted;
    assign m_rollback_due    = res_reg.rollback_due;
    assign m_live_slave      = res_reg.live.slave;
    assign m_live_baud       = res_reg.live.baud;
    assign m_live_parity     = res_reg.live.parity;
    assign m_live_stop       = res_reg.live.stop;
    assign m_staged_slave    = res_reg.staged.slave;
    assign m_staged_baud     = res_reg.staged.baud;
    assign m_staged_parity   = res_reg.staged.parity;
    assign m_staged_stop     = res_reg.staged.stop;
    assign m_revision        = res_reg.revision;
    assign m_confirm_pending = res_reg.pending;

endmodule

FILE: sv/lscr_checker.sv
`timescale 1ns / 1ps

module lscr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_live_parity,
    input logic [1:0]  m_live_stop,
    input logic [1:0]  m_staged_stop
);
    import lscr_pkg::*;

    // output word must hold while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // a new result only appears after an input word was taken and passed the input register
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result word without a matching input word");

    // live and staged copies only ever hold legal stop codes, and live a legal parity code
    a_copy_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_live_stop == STOP_ONE || m_live_stop == STOP_TWO) &&
                     (m_staged_stop == STOP_ONE || m_staged_stop == STOP_TWO) &&
                     (m_live_parity <= PARITY_MAX)))
        else $error("illegal settings copy on output");

    a_ready_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> s_ready)
        else $error("input not ready after reset");

endmodule

bind link_settings_commit_rollback lscr_checker u_lscr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_live_parity (m_live_parity),
    .m_live_stop   (m_live_stop),
    .m_staged_stop (m_staged_stop)
);
